FILE: src/deferred_release_timer_queue_core_defines.svh
// Assertion macros for the deferred release timer queue.
// Included by files that carry concurrent assertions; no other dependencies.
`ifndef DEFERRED_RELEASE_TIMER_QUEUE_CORE_DEFINES_SVH
`define DEFERRED_RELEASE_TIMER_QUEUE_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define DRTQ_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define DRTQ_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define DRTQ_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg)
`define DRTQ_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

FILE: src/drtq_pkg.sv
// Shared types and constants for the deferred release timer queue.
// No dependencies.
package drtq_pkg;

  localparam int MAX_RESULTS = 16;
  localparam int NW = $clog2(MAX_RESULTS + 1);

  localparam logic STATUS_RELEASED = 1'b0;
  localparam logic STATUS_FULL     = 1'b1;

  typedef enum logic [1:0] {
    OP_ENQUEUE = 2'd0,
    OP_TICK    = 2'd1,
    OP_PURGE   = 2'd2,
    OP_NONE    = 2'd3
  } opcode_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_INSERT,
    S_REL_RD,
    S_REL_CMP,
    S_OUT
  } state_t;

  typedef struct packed {
    logic [9:0]  kind;
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [31:0] pos_z;
    logic [31:0] heading;
    logic [15:0] flags;
    logic [31:0] ctx;
  } payload_t;

  typedef struct packed {
    logic [31:0] due;
    payload_t    pay;
  } entry_t;

endpackage

FILE: src/drtq_cmd_if.sv
// Command channel: enqueue, tick and purge transactions.
// No dependencies.
interface drtq_cmd_if;
  logic               valid;
  logic               ready;
  logic [1:0]         opcode;
  logic signed [31:0] delay_ticks;
  logic [9:0]         kind;
  logic [31:0]        pos_x;
  logic [31:0]        pos_y;
  logic [31:0]        pos_z;
  logic [31:0]        heading;
  logic [15:0]        spawn_flags;
  logic [31:0]        context_tag;

  modport source (
    output valid, opcode, delay_ticks, kind, pos_x, pos_y, pos_z, heading,
           spawn_flags, context_tag,
    input  ready
  );
  modport sink (
    input  valid, opcode, delay_ticks, kind, pos_x, pos_y, pos_z, heading,
           spawn_flags, context_tag,
    output ready
  );
endinterface

FILE: src/drtq_rel_if.sv
// Release channel: released or refused payload transactions.
// No dependencies.
interface drtq_rel_if;
  logic        valid;
  logic        ready;
  logic        status;
  logic [9:0]  out_kind;
  logic [31:0] out_pos_x;
  logic [31:0] out_pos_y;
  logic [31:0] out_pos_z;
  logic [31:0] out_heading;
  logic [15:0] out_flags;
  logic [31:0] out_context;
  logic        last;

  modport source (
    output valid, status, out_kind, out_pos_x, out_pos_y, out_pos_z, out_heading,
           out_flags, out_context, last,
    input  ready
  );
  modport sink (
    input  valid, status, out_kind, out_pos_x, out_pos_y, out_pos_z, out_heading,
           out_flags, out_context, last,
    output ready
  );
endinterface

FILE: src/drtq_store.sv
// Entry store: one write port, one registered read port.
// Depends on drtq_pkg.
module drtq_store #(
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic            clk,
  input  logic            we,
  input  logic [AW-1:0]   waddr,
  input  drtq_pkg::entry_t wdata,
  input  logic [AW-1:0]   raddr,
  output drtq_pkg::entry_t rdata
);
  import drtq_pkg::*;

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end
endmodule

FILE: src/deferred_release_timer_queue_core.sv
// Deferred release timer queue: due-time ordered queue in a circular store.
// Depends on drtq_pkg, drtq_cmd_if, drtq_rel_if, drtq_store and the defines header.
//
//   channel  modport  moves
//   cmd      sink     enqueue / tick / purge transactions
//   rel      source   released or refused payloads, last marks the final one
//
// Enqueue: entries ahead of the slot are read and compared, those behind it are read
// and written one place back, then the new entry is written; immediate and refused
// ones go straight to the output handshake. Tick: the head is read and compared;
// each due entry is taken, then output after a further read and compare set last,
// waiting on output stalls; purge acts in idle. One transaction at a time.
// Synchronous reset empties the queue and zeroes time; no clearing pass.
`include "deferred_release_timer_queue_core_defines.svh"
module deferred_release_timer_queue_core #(
  parameter int QUEUE_DEPTH = 16
) (
  input logic        clk,
  input logic        rst,
  drtq_cmd_if.sink   cmd,
  drtq_rel_if.source rel
);
  import drtq_pkg::*;

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  state_t             state, state_next;
  logic [CW-1:0]      count, count_next;
  logic [AW-1:0]      head, head_next;
  logic [31:0]        now, now_next;
  logic [CW-1:0]      idx, idx_next;
  logic [CW-1:0]      sh, sh_next;
  logic [NW-1:0]      n, n_next;
  logic               pending, pending_next;
  opcode_t            op, op_next;
  entry_t             item, item_next;
  logic signed [31:0] delay, delay_next;
  logic               out_status, out_status_next;
  payload_t           out_pay, out_pay_next;
  logic               out_last, out_last_next;

  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  logic [AW-1:0]      mem_raddr;
  entry_t             mem_wdata;
  entry_t             rdata;

  logic [31:0]        rem;
  logic signed [31:0] cmp_ref;
  logic               cmp_le;
  logic               rel_due;
  payload_t           cmd_pay;
  logic               purge_acc;

  function automatic logic [AW-1:0] phys(input logic [AW-1:0] hd, input logic [CW-1:0] li);
    logic [AW:0] s;
    s = {1'b0, hd} + (AW+1)'(li);
    if (s >= (AW+1)'(QUEUE_DEPTH)) begin
      s = s - (AW+1)'(QUEUE_DEPTH);
    end
    return s[AW-1:0];
  endfunction

  drtq_store #(.DEPTH(QUEUE_DEPTH)) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (rdata)
  );

  // shared remaining-time compare
  assign rem     = rdata.due - now;
  assign cmp_le  = $signed(rem) <= cmp_ref;
  assign rel_due = (count != '0) && (n < NW'(MAX_RESULTS)) && cmp_le;

  assign cmd_pay = '{kind: cmd.kind, pos_x: cmd.pos_x, pos_y: cmd.pos_y,
                     pos_z: cmd.pos_z, heading: cmd.heading,
                     flags: cmd.spawn_flags, ctx: cmd.context_tag};

  assign purge_acc = cmd.valid && cmd.ready && (cmd.opcode == OP_PURGE);

  assign cmd.ready       = (state == S_IDLE);
  assign rel.valid       = (state == S_OUT);
  assign rel.status      = out_status;
  assign rel.out_kind    = out_pay.kind;
  assign rel.out_pos_x   = out_pay.pos_x;
  assign rel.out_pos_y   = out_pay.pos_y;
  assign rel.out_pos_z   = out_pay.pos_z;
  assign rel.out_heading = out_pay.heading;
  assign rel.out_flags   = out_pay.flags;
  assign rel.out_context = out_pay.ctx;
  assign rel.last        = out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      count   <= '0;
      head    <= '0;
      now     <= '0;
      n       <= '0;
      pending <= 1'b0;
    end else begin
      state   <= state_next;
      count   <= count_next;
      head    <= head_next;
      now     <= now_next;
      n       <= n_next;
      pending <= pending_next;
    end
  end

  always_ff @(posedge clk) begin
    idx        <= idx_next;
    sh         <= sh_next;
    op         <= op_next;
    item       <= item_next;
    delay      <= delay_next;
    out_status <= out_status_next;
    out_pay    <= out_pay_next;
    out_last   <= out_last_next;
  end

  always_comb begin
    state_next      = state;
    count_next      = count;
    head_next       = head;
    now_next        = now;
    idx_next        = idx;
    sh_next         = sh;
    n_next          = n;
    pending_next    = pending;
    op_next         = op;
    item_next       = item;
    delay_next      = delay;
    out_status_next = out_status;
    out_pay_next    = out_pay;
    out_last_next   = out_last;
    mem_we          = 1'b0;
    mem_waddr       = phys(head, sh);
    mem_wdata       = rdata;
    mem_raddr       = phys(head, idx);
    cmp_ref         = '0;

    unique case (state)
      S_IDLE: begin
        if (cmd.valid) begin
          op_next       = opcode_t'(cmd.opcode);
          delay_next    = cmd.delay_ticks;
          item_next.due = now + cmd.delay_ticks;
          item_next.pay = cmd_pay;
          unique case (opcode_t'(cmd.opcode))
            OP_ENQUEUE: begin
              if (cmd.delay_ticks <= 32'sd0) begin
                out_status_next = STATUS_RELEASED;
                out_pay_next    = cmd_pay;
                out_last_next   = 1'b1;
                state_next      = S_OUT;
              end else if (count >= CW'(QUEUE_DEPTH)) begin
                out_status_next = STATUS_FULL;
                out_pay_next    = cmd_pay;
                out_last_next   = 1'b1;
                state_next      = S_OUT;
              end else begin
                idx_next   = '0;
                state_next = S_SCAN_RD;
              end
            end
            OP_TICK: begin
              n_next       = '0;
              pending_next = 1'b0;
              state_next   = S_REL_RD;
            end
            OP_PURGE: begin
              count_next = '0;
              head_next  = '0;
            end
            default: begin
            end
          endcase
        end
      end
      S_SCAN_RD: begin
        if (idx == count) begin
          sh_next    = count;
          state_next = S_SHIFT_RD;
        end else begin
          mem_raddr  = phys(head, idx);
          state_next = S_SCAN_CMP;
        end
      end
      S_SCAN_CMP: begin
        cmp_ref = delay;
        if (cmp_le) begin
          idx_next   = idx + CW'(1);
          state_next = S_SCAN_RD;
        end else begin
          sh_next    = count;
          state_next = S_SHIFT_RD;
        end
      end
      S_SHIFT_RD: begin
        if (sh == idx) begin
          state_next = S_INSERT;
        end else begin
          mem_raddr  = phys(head, sh - CW'(1));
          state_next = S_SHIFT_WR;
        end
      end
      S_SHIFT_WR: begin
        mem_we     = 1'b1;
        mem_waddr  = phys(head, sh);
        mem_wdata  = rdata;
        sh_next    = sh - CW'(1);
        state_next = S_SHIFT_RD;
      end
      S_INSERT: begin
        mem_we     = 1'b1;
        mem_waddr  = phys(head, idx);
        mem_wdata  = item;
        count_next = count + CW'(1);
        state_next = S_IDLE;
      end
      S_REL_RD: begin
        mem_raddr  = head;
        state_next = S_REL_CMP;
      end
      S_REL_CMP: begin
        cmp_ref = '0;
        if (pending) begin
          // held release goes out once we know whether another follows
          out_last_next = !rel_due;
          state_next    = S_OUT;
        end else if (rel_due) begin
          out_status_next = STATUS_RELEASED;
          out_pay_next    = rdata.pay;
          head_next       = phys(head, CW'(1));
          count_next      = count - CW'(1);
          n_next          = n + NW'(1);
          pending_next    = 1'b1;
          state_next      = S_REL_RD;
        end else begin
          now_next   = now + 32'd1;
          state_next = S_IDLE;
        end
      end
      S_OUT: begin
        if (rel.ready) begin
          pending_next = 1'b0;
          if (out_last) begin
            if (op == OP_TICK) begin
              now_next = now + 32'd1;
            end
            state_next = S_IDLE;
          end else begin
            state_next = S_REL_RD;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  `DRTQ_ASSERT_IMPLY(a_count_bound, clk, rst, 1'b1, count <= CW'(QUEUE_DEPTH), "count over depth")
  `DRTQ_ASSERT_IMPLY(a_one_at_a_time, clk, rst, rel.valid, !cmd.ready, "busy overlap")
  `DRTQ_ASSERT_NEXT(a_purge_empties, clk, rst, purge_acc, count == '0, "purge left entries")
  `DRTQ_ASSERT_IMPLY(a_release_cap, clk, rst, 1'b1, n <= NW'(MAX_RESULTS), "too many releases")
endmodule

FILE: dv/testbench.sv
// Self-checking testbench for deferred_release_timer_queue_core: directed and random
// enqueue/tick/purge traffic with a built-in due-time queue predictor and scoreboard.
// Depends on drtq_pkg, drtq_cmd_if, drtq_rel_if and the core RTL.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import drtq_pkg::*;

  localparam int QUEUE_DEPTH  = 16;
  localparam int RANDOM_ITEMS = 250;
  localparam int DRAIN_CYCLES = 150;
  localparam int CYCLE_LIMIT  = 500000;

  typedef struct packed {
    logic     status;
    payload_t pay;
    logic     last;
  } release_t;

  class release_tracker;
    logic [31:0] now_ticks;
    entry_t      pending_entries[$];
    release_t    expected_releases[$];
    int          mismatches;

    function new();
      now_ticks  = '0;
      mismatches = 0;
    endfunction

    function int pending();
      return expected_releases.size();
    endfunction

    task report(string msg);
      mismatches++;
      $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    function void note_command(opcode_t op, logic signed [31:0] delay, payload_t pay);
      release_t r;
      entry_t   e;
      int       pos;
      int       n;
      case (op)
        OP_ENQUEUE: begin
          if (delay <= 0) begin
            r.status = STATUS_RELEASED;
            r.pay    = pay;
            r.last   = 1'b1;
            expected_releases.push_back(r);
          end else if (pending_entries.size() >= QUEUE_DEPTH) begin
            r.status = STATUS_FULL;
            r.pay    = pay;
            r.last   = 1'b1;
            expected_releases.push_back(r);
          end else begin
            // goes behind every entry due at or before the new one
            pos = 0;
            while (pos < pending_entries.size() &&
                   int'(pending_entries[pos].due - now_ticks) <= delay)
              pos++;
            e.due = now_ticks + delay;
            e.pay = pay;
            pending_entries.insert(pos, e);
          end
        end
        OP_TICK: begin
          n = 0;
          while (n < pending_entries.size() && n < MAX_RESULTS &&
                 int'(pending_entries[n].due - now_ticks) <= 0)
            n++;
          for (int i = 0; i < n; i++) begin
            r.status = STATUS_RELEASED;
            r.pay    = pending_entries[0].pay;
            r.last   = (i == n - 1);
            expected_releases.push_back(r);
            void'(pending_entries.pop_front());
          end
          now_ticks++;
        end
        OP_PURGE: pending_entries.delete();
        default: ;
      endcase
    endfunction

    task check_release(release_t got);
      release_t want;
      string    bad;
      if (expected_releases.size() == 0) begin
        report($sformatf("release with nothing expected (kind %0h ctx %0h)",
                         got.pay.kind, got.pay.ctx));
      end else begin
        want = expected_releases.pop_front();
        bad  = "";
        if (got.status !== want.status)           bad = {bad, " status"};
        if (got.pay.kind !== want.pay.kind)       bad = {bad, " kind"};
        if (got.pay.pos_x !== want.pay.pos_x)     bad = {bad, " pos_x"};
        if (got.pay.pos_y !== want.pay.pos_y)     bad = {bad, " pos_y"};
        if (got.pay.pos_z !== want.pay.pos_z)     bad = {bad, " pos_z"};
        if (got.pay.heading !== want.pay.heading) bad = {bad, " heading"};
        if (got.pay.flags !== want.pay.flags)     bad = {bad, " flags"};
        if (got.pay.ctx !== want.pay.ctx)         bad = {bad, " context"};
        if (got.last !== want.last)               bad = {bad, " last"};
        if (bad != "")
          report($sformatf("wrong%s: got %h want %h", bad, got, want));
      end
    endtask
  endclass

  logic clk;
  logic rst;

  drtq_cmd_if cmd_ch ();
  drtq_rel_if rel_ch ();

  deferred_release_timer_queue_core #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) DUT (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_ch),
    .rel (rel_ch)
  );

  release_tracker tracker = new();

  int unsigned cycles;
  int unsigned burst_left;
  int unsigned stall_left;
  int unsigned mode_left;
  bit          choppy;
  logic        ready_next;
  int          items_sent;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cmd_ch.valid       = 1'b0;
    cmd_ch.opcode      = OP_NONE;
    cmd_ch.delay_ticks = '0;
    cmd_ch.kind        = '0;
    cmd_ch.pos_x       = '0;
    cmd_ch.pos_y       = '0;
    cmd_ch.pos_z       = '0;
    cmd_ch.heading     = '0;
    cmd_ch.spawn_flags = '0;
    cmd_ch.context_tag = '0;
    rel_ch.ready       = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d releases outstanding", cycles,
               tracker.pending());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // release side: free-running stretches alternate with choppy ones
  always @(negedge clk) begin
    if (mode_left == 0) begin
      choppy    = ($urandom_range(0, 2) != 0);
      mode_left = $urandom_range(20, 200);
    end else begin
      mode_left--;
    end
    if (stall_left > 0) begin
      stall_left--;
      ready_next = 1'b0;
    end else if (!choppy) begin
      ready_next = 1'b1;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 9);
      ready_next = 1'b0;
    end else begin
      ready_next = ($urandom_range(0, 3) != 0);
    end
    rel_ch.ready <= ready_next;
  end

  always @(posedge clk) begin
    release_t got;
    payload_t pay;
    if (!rst) begin
      if (cmd_ch.valid && cmd_ch.ready) begin
        pay.kind    = cmd_ch.kind;
        pay.pos_x   = cmd_ch.pos_x;
        pay.pos_y   = cmd_ch.pos_y;
        pay.pos_z   = cmd_ch.pos_z;
        pay.heading = cmd_ch.heading;
        pay.flags   = cmd_ch.spawn_flags;
        pay.ctx     = cmd_ch.context_tag;
        tracker.note_command(opcode_t'(cmd_ch.opcode), cmd_ch.delay_ticks, pay);
      end
      if (rel_ch.valid && rel_ch.ready) begin
        got.status      = rel_ch.status;
        got.pay.kind    = rel_ch.out_kind;
        got.pay.pos_x   = rel_ch.out_pos_x;
        got.pay.pos_y   = rel_ch.out_pos_y;
        got.pay.pos_z   = rel_ch.out_pos_z;
        got.pay.heading = rel_ch.out_heading;
        got.pay.flags   = rel_ch.out_flags;
        got.pay.ctx     = rel_ch.out_context;
        got.last        = rel_ch.last;
        tracker.check_release(got);
      end
    end
  end

  function automatic payload_t random_payload();
    payload_t p;
    p.kind    = $urandom_range(0, 1023);
    p.pos_x   = $urandom;
    p.pos_y   = $urandom;
    p.pos_z   = $urandom;
    p.heading = $urandom;
    p.flags   = $urandom_range(0, 65535);
    p.ctx     = $urandom;
    return p;
  endfunction

  function automatic logic signed [31:0] random_delay();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 6);
    if (r < 80) return $urandom_range(1, 40);
    if (r < 88) return -$signed($urandom_range(0, 5));
    if (r < 94) return $urandom;
    case ($urandom_range(0, 2))
      0:       return 32'sh7fffffff;
      1:       return 32'sh80000000;
      default: return 32'sh00000001;
    endcase
  endfunction

  // one transaction; valid stays high inside a burst
  task automatic send_cmd(opcode_t op, logic signed [31:0] delay, payload_t pay);
    int unsigned gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
    end
    burst_left--;
    @(negedge clk);
    if (gap > 0) begin
      cmd_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    cmd_ch.valid       <= 1'b1;
    cmd_ch.opcode      <= op;
    cmd_ch.delay_ticks <= delay;
    cmd_ch.kind        <= pay.kind;
    cmd_ch.pos_x       <= pay.pos_x;
    cmd_ch.pos_y       <= pay.pos_y;
    cmd_ch.pos_z       <= pay.pos_z;
    cmd_ch.heading     <= pay.heading;
    cmd_ch.spawn_flags <= pay.flags;
    cmd_ch.context_tag <= pay.ctx;
    do @(posedge clk); while (!cmd_ch.ready);
    if (op != OP_NONE) items_sent++;
  endtask

  task automatic wait_all_released();
    @(negedge clk);
    cmd_ch.valid <= 1'b0;
    burst_left = 0;
    while (tracker.pending() > 0) @(negedge clk);
  endtask

  task automatic random_mixed_item();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50)      send_cmd(OP_ENQUEUE, random_delay(), random_payload());
    else if (r < 90) send_cmd(OP_TICK, $urandom, random_payload());
    else if (r < 95) send_cmd(OP_PURGE, $urandom, random_payload());
    else             send_cmd(OP_NONE, $urandom, random_payload());
  endtask

  initial begin
    payload_t ones;
    logic signed [31:0] fill_delays [16];
    fill_delays = '{32'sh7fffffff, 3, 2, 1, 1, 3, 2, 1, 5, 4, 1, 2, 3, 1, 2, 1};
    ones = '1;
    rst  = 1'b1;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    @(posedge clk);

    // immediate releases at the delay and payload extremes
    send_cmd(OP_ENQUEUE, 32'sh0, ones);
    send_cmd(OP_ENQUEUE, -32'sh1, '0);
    send_cmd(OP_ENQUEUE, 32'sh80000000, random_payload());
    send_cmd(OP_TICK, '0, random_payload());
    send_cmd(OP_PURGE, '0, random_payload());
    send_cmd(OP_NONE, 32'sh5, random_payload());
    // fill with ties, head inserts and the longest delay, then one refused
    foreach (fill_delays[i]) send_cmd(OP_ENQUEUE, fill_delays[i], random_payload());
    send_cmd(OP_ENQUEUE, 32'sh4, random_payload());
    repeat (3) send_cmd(OP_TICK, '1, random_payload());
    wait_all_released();

    while (items_sent < RANDOM_ITEMS) begin
      if ($urandom_range(0, 99) < 25) begin
        repeat ($urandom_range(16, 19))
          send_cmd(OP_ENQUEUE, $urandom_range(1, 3), random_payload());
        repeat ($urandom_range(3, 5)) send_cmd(OP_TICK, $urandom, random_payload());
      end else begin
        repeat (20) random_mixed_item();
      end
      if ($urandom_range(0, 3) == 0) wait_all_released();
    end

    wait_all_released();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (tracker.mismatches == 0 && tracker.pending() == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
